[hdl/itoa_pkg.sv]
`timescale 1ns / 1ps
// Package for the integer to ASCII converter: widths, register map and helpers.
// Used by every module of the block; depends on nothing.
package itoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int BASE_W      = 6;
	localparam int CHAR_W      = 8;
	localparam int DIG_W       = 6;
	localparam int STORE_DEPTH = VALUE_WIDTH;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int STEP_W      = $clog2(VALUE_WIDTH);
	localparam int APB_ADDR_W  = 2;
	localparam int APB_DATA_W  = 32;

	localparam logic [APB_ADDR_W-1:0] REG_NUMBER_BASE = '0;

	localparam logic [BASE_W-1:0] BASE_DEFAULT = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MIN     = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX     = BASE_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic             done;
		logic [DIG_W-1:0] rem;
	} div_stat_t;

	function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		if (b < BASE_MIN) begin
			r = BASE_DEFAULT;
		end else if (b > BASE_MAX) begin
			r = BASE_MAX;
		end else begin
			r = b;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIG_W'(10)) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
		end
		return c;
	endfunction

endpackage

[hdl/itoa_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on itoa_pkg.
module itoa_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [itoa_pkg::VALUE_WIDTH-1:0]  dividend,
	input  logic [itoa_pkg::BASE_W-1:0]       divisor,
	output logic [itoa_pkg::VALUE_WIDTH-1:0]  quotient,
	output itoa_pkg::div_stat_t               stat
);
	import itoa_pkg::*;

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIG_W-1:0]       rem_q;
	logic [BASE_W-1:0]      dsr_q;
	logic [STEP_W-1:0]      step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIG_W:0]         trial;
	logic [DIG_W:0]         diff;
	logic                   qbit;

	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], qbit};
			rem_q <= qbit ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

[hdl/itoa_store.sv]
`timescale 1ns / 1ps
// Digit store: one write port and one registered read port.
// Depends on itoa_pkg.
module itoa_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [itoa_pkg::IDX_W-1:0]    waddr,
	input  logic [itoa_pkg::DIG_W-1:0]    wdata,
	input  logic [itoa_pkg::IDX_W-1:0]    raddr,
	output logic [itoa_pkg::DIG_W-1:0]    rdata
);
	import itoa_pkg::*;

	logic [DIG_W-1:0] mem_q [STORE_DEPTH];
	logic [DIG_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/integer_to_ascii_radix.sv]
`timescale 1ns / 1ps
// Top level of the integer to ASCII converter: APB register, sequencer, output stage.
// Depends on itoa_pkg, itoa_div and itoa_store.
//
// Channel   Direction  Contents
// s_axis    in         tdata: value[31:0]; tuser: signed_mode
// m_axis    out        tdata: ascii_char[7:0]; tlast: last
// apb       in/out     register 0 at byte address 0: number_base[5:0]
//
// Each digit is produced by one division in the bit-serial divider and written to the
// store; each character is then read back from the store and loaded into the output
// register. A new number is taken once the last character sits in the output register.
// A stalled output holds the sequencer in its sign and emit states. Reset clears the
// control state and sets the radix to ten.
module integer_to_ascii_radix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [31:0]                        s_axis_tdata,  // value[31:0]
	input  logic [0:0]                         s_axis_tuser,  // signed_mode
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // ascii_char[7:0]
	output logic                               m_axis_tlast,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [itoa_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [itoa_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [itoa_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import itoa_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SIGN  = 6'b000010,
		ST_START = 6'b000100,
		ST_WAIT  = 6'b001000,
		ST_READ  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [BASE_W-1:0]      base_q;
	logic [VALUE_WIDTH-1:0] work_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic                   out_last_q;

	logic                   in_acc;
	logic                   out_free;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] quotient;
	div_stat_t              dstat;
	logic                   st_we;
	logic [DIG_W-1:0]       st_rdata;
	logic                   load_sign;
	logic                   load_digit;

	// The map holds a single register, so writes do not decode the address.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_NUMBER_BASE) ? APB_DATA_W'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_DEFAULT;
		end else if (psel && penable && pwrite && pready) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign neg           = s_axis_tuser[0] && s_axis_tdata[VALUE_WIDTH-1];
	assign mag           = neg ? (~s_axis_tdata[VALUE_WIDTH-1:0] + VALUE_WIDTH'(1))
	                           : s_axis_tdata[VALUE_WIDTH-1:0];
	assign div_start     = (state_q == ST_START);
	assign st_we         = (state_q == ST_WAIT) && dstat.done;
	assign load_sign     = (state_q == ST_SIGN) && out_free;
	assign load_digit    = (state_q == ST_EMIT) && out_free;

	itoa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (work_q),
		.divisor  (eff_base(base_q)),
		.quotient (quotient),
		.stat     (dstat)
	);

	itoa_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (dstat.rem),
		.raddr (idx_q),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= neg ? ST_SIGN : ST_START;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (dstat.done) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (quotient == '0 || cnt_q == CNT_W'(STORE_DEPTH - 1)) begin
							idx_q   <= cnt_q[IDX_W-1:0];
							state_q <= ST_READ;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			work_q <= mag;
		end else if (st_we) begin
			work_q <= quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_sign || load_digit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (load_digit) begin
			out_char_q <= digit_char(st_rdata);
			out_last_q <= (idx_q == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

endmodule

[hdl/itoa_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the integer to ASCII converter, bound to the top level.
// Depends on itoa_pkg.
module itoa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);
	import itoa_pkg::*;

	// A stalled output transaction keeps its character and flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// Only a sign, a decimal digit or an upper-case letter is ever sent.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		(m_axis_tdata == CHAR_MINUS) ||
		(m_axis_tdata >= CHAR_ZERO && m_axis_tdata <= 8'h39) ||
		(m_axis_tdata >= CHAR_A && m_axis_tdata <= 8'h5A))
		else $error("illegal output character");

	// The sign never closes a number.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata == CHAR_MINUS |-> !m_axis_tlast)
		else $error("sign flagged as last character");

	// A number is converted one at a time: input closes right after a transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a number is in progress");

endmodule

bind integer_to_ascii_radix itoa_chk u_itoa_chk (.*);

[verif/integer_to_ascii_radix_test.sv]
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_radix: streams numbers in, predicts the characters
// for each radix setting it writes, and checks each output transaction. Needs only the RTL.
module integer_to_ascii_radix_test;
	import itoa_pkg::*;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_UPPER = 8'h41;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata;  // value[31:0]
	logic [0:0]            s_axis_tuser;  // signed_mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;  // ascii_char[7:0]
	logic                  m_axis_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	text_char_t  pending_chars[$];
	logic [5:0]  radix_reg;
	bit          idle_on;
	bit          offering;
	bit          long_hold_request;
	int          errors;
	int          numbers_sent;
	int          chars_checked;
	int          radix_writes;

	integer_to_ascii_radix dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("[integer_to_ascii_radix] ERROR");
		$finish;
	end

	function automatic int gap_length();
		int len;
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(15, 50);
		end else begin
			len = $urandom_range(1, 3);
		end
		return len;
	endfunction

	function automatic void predict_text(input logic [31:0] value, input logic signed_mode);
		logic [5:0]  radix;
		logic [31:0] magnitude;
		logic [5:0]  digits[$];
		logic [5:0]  d;
		text_char_t  c;
		if (radix_reg < 6'd2) begin
			radix = 6'd10;
		end else if (radix_reg > 6'd36) begin
			radix = 6'd36;
		end else begin
			radix = radix_reg;
		end
		magnitude = value;
		if (signed_mode && value[31]) begin
			c.ch = ASCII_MINUS;
			c.last = 1'b0;
			pending_chars.push_back(c);
			magnitude = -value;
		end
		do begin
			digits.push_front(6'(magnitude % 32'(radix)));
			magnitude = magnitude / 32'(radix);
		end while (magnitude != 0);
		while (digits.size() > 0) begin
			d = digits.pop_front();
			c.ch = (d < 6'd10) ? ASCII_ZERO + 8'(d) : ASCII_UPPER + 8'(d) - 8'd10;
			c.last = (digits.size() == 0);
			pending_chars.push_back(c);
		end
	endfunction

	task automatic send_number(input logic [31:0] value, input logic signed_mode);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			if (offering) begin
				s_axis_tvalid <= 1'b0;
				offering = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= signed_mode;
		offering = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_text(value, signed_mode);
		numbers_sent++;
	endtask

	task automatic release_input();
		if (offering) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic wait_for_drain();
		release_input();
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [5:0] radix);
		wait_for_drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_NUMBER_BASE;
		pwdata <= APB_DATA_W'(radix);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		radix_reg = radix;
		radix_writes++;
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4: v = $urandom_range(0, 50);
			5: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h8000_0001;
				endcase
			end
			default: v = $urandom >> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	task automatic test_reset_radix();
		send_number(32'd0, 1'b0);
		send_number(32'd0, 1'b1);
		send_number(32'd1, 1'b0);
		send_number(32'd9, 1'b1);
		send_number(32'd10, 1'b0);
		send_number(32'hFFFF_FFFF, 1'b0);
		send_number(32'hFFFF_FFFF, 1'b1);
		send_number(32'h8000_0000, 1'b1);
		send_number(32'h8000_0000, 1'b0);
		send_number(32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_radix_extremes();
		write_radix(6'd2);
		send_number(32'hFFFF_FFFF, 1'b0);
		send_number(32'h8000_0000, 1'b1);
		send_number(32'h5555_5555, 1'b0);
		write_radix(6'd36);
		send_number(32'd35, 1'b0);
		send_number(32'hFFFF_FFFF, 1'b0);
		send_number(32'h8000_0000, 1'b1);
		write_radix(6'd0);
		send_number(32'd12345, 1'b0);
		write_radix(6'd1);
		send_number(32'd100, 1'b1);
		write_radix(6'd63);
		send_number(32'hFFFF_FFFF, 1'b0);
		write_radix(6'd37);
		send_number(32'd36, 1'b0);
		write_radix(6'd16);
		send_number(32'hDEAD_BEEF, 1'b1);
		send_number(32'hDEAD_BEEF, 1'b0);
	endtask

	task automatic test_random_numbers();
		logic [5:0] radix;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: radix = 6'd0;
				1: radix = 6'd63;
				2: radix = 6'd2;
				default: radix = 6'($urandom_range(0, 63));
			endcase
			write_radix(radix);
			idle_on = (phase != 3);
			for (int i = 0; i < 18; i++) begin
				send_number(random_value(), 1'($urandom_range(0, 1)));
			end
			idle_on = 1'b1;
		end
	endtask

	task automatic test_output_stall();
		write_radix(6'd10);
		long_hold_request = 1'b1;
		for (int i = 0; i < 5; i++) begin
			send_number(random_value(), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++) begin
			send_number(random_value(), 1'($urandom_range(0, 1)));
			if (i == 2) begin
				wait_for_drain();
			end
		end
	endtask

	initial begin : result_sink
		text_char_t exp_char;
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_chars.size() == 0) begin
					$error("unexpected character %h last %b", m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					exp_char = pending_chars.pop_front();
					chars_checked++;
					if (m_axis_tdata !== exp_char.ch) begin
						$error("ascii_char mismatch: expected %h actual %h",
							exp_char.ch, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== exp_char.last) begin
						$error("last mismatch: expected %b actual %b",
							exp_char.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if (long_hold_request) begin
				hold_left = LONG_HOLD;
				long_hold_request = 1'b0;
			end else if (hold_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
				hold_left = gap_length();
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		radix_reg = 6'd10;
		idle_on = 1'b1;
		offering = 1'b0;
		long_hold_request = 1'b0;
		errors = 0;
		numbers_sent = 0;
		chars_checked = 0;
		radix_writes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_radix();
		test_radix_extremes();
		test_random_numbers();
		test_output_stall();
		test_drain_pause();

		wait_for_drain();
		$display("Checked %0d numbers as %0d characters across %0d radix writes,",
			numbers_sent, chars_checked, radix_writes);
		$display("with radix extremes, signed limits, output stalls and drain pauses.");
		if (errors == 0) begin
			$display("[integer_to_ascii_radix] OK");
		end else begin
			$display("[integer_to_ascii_radix] ERROR");
		end
		$finish;
	end

endmodule
